FILE: rtl/i2r_pkg.sv
// Shared types, constants and digit-to-symbol functions for the Roman numeral converter.
`timescale 1ns / 1ps

package i2r_pkg;

  localparam int VALUE_W  = 13;            // binary input width
  localparam int DIGITS   = 4;             // thousands, hundreds, tens, units
  localparam int BCD_W    = 4 * DIGITS;
  localparam int SYM_W    = 3;
  localparam int CNT_W    = 4;             // double-dabble shift counter
  localparam int STEP_W   = 3;
  localparam int POS_W    = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CNT_W-1:0]  LAST_SHIFT = CNT_W'(VALUE_W - 1);
  localparam logic [POS_W-1:0]  POS_THOU   = 2'd3;
  localparam logic [3:0]        MAX_THOU   = 4'd4;

  // letter codes
  localparam logic [SYM_W-1:0] SYM_I = 3'd0;
  localparam logic [SYM_W-1:0] SYM_V = 3'd1;
  localparam logic [SYM_W-1:0] SYM_X = 3'd2;
  localparam logic [SYM_W-1:0] SYM_L = 3'd3;
  localparam logic [SYM_W-1:0] SYM_C = 3'd4;
  localparam logic [SYM_W-1:0] SYM_D = 3'd5;
  localparam logic [SYM_W-1:0] SYM_M = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;   // capture input beat, clear BCD
    logic shift;  // one double-dabble iteration
    logic step;   // emit one symbol or skip to the next digit
  } cmd_t;

  typedef struct packed {
    logic conv_done;  // final shift in progress
    logic run_done;   // current step ends the numeral
    logic out_free;   // output register can take a beat
  } stat_t;

  // number of symbols a digit produces at a position
  function automatic logic [STEP_W-1:0] digit_count(input logic [3:0] d,
                                                   input logic [POS_W-1:0] pos);
    logic [STEP_W-1:0] n;
    n = '0;
    if (pos == POS_THOU) begin
      n = (d <= MAX_THOU) ? d[STEP_W-1:0] : '0;
    end else begin
      case (d)
        4'd4, 4'd9:                n = 3'd2;
        4'd5, 4'd6, 4'd7, 4'd8:    n = STEP_W'(d - 4'd4);
        4'd1, 4'd2, 4'd3:          n = d[STEP_W-1:0];
        default:                   n = '0;
      endcase
    end
    return n;
  endfunction

  // letter for symbol index step of a digit at a position
  function automatic logic [SYM_W-1:0] digit_symbol(input logic [3:0] d,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [STEP_W-1:0] step);
    logic [SYM_W-1:0] one;
    logic [SYM_W-1:0] five;
    logic [SYM_W-1:0] ten;
    logic [SYM_W-1:0] s;
    one  = {pos, 1'b0};
    five = one + 3'd1;
    ten  = one + 3'd2;
    if (pos == POS_THOU) begin
      s = SYM_M;
    end else if (d == 4'd9) begin
      s = (step == '0) ? one : ten;
    end else if (d == 4'd4) begin
      s = (step == '0) ? one : five;
    end else if (d >= 4'd5) begin
      s = (step == '0) ? five : one;
    end else begin
      s = one;
    end
    return s;
  endfunction

endpackage

FILE: rtl/integer_to_roman_numeral_top.sv
// Top level of the integer to Roman numeral converter.
`timescale 1ns / 1ps
//
// Channel  Dir  Bits                          Beat
// s_axis   in   tdata[12:0] value             one integer 0..4999
// m_axis   out  tdata[2:0] symbol, tlast=last one letter, tlast on final letter
//
// An item is taken while idle, converted to BCD by the shift-and-add-3 loop,
// then emitted one symbol per cycle while m_tready allows, plus one step past
// each finished digit; at most 16 symbols and 3 digit steps per item, from the
// single symbol emitter. s_tready is high only while idle; the last symbol may
// still wait in the output register while the next item is accepted.
// A stalled m_tready holds the emitter. Reset (rst, synchronous) returns to
// idle and drops any pending beat. Zero gives no beats.

module integer_to_roman_numeral_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [i2r_pkg::IN_TDATA_W-1:0]     s_tdata,   // [12:0] value
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [i2r_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [2:0] symbol
  output logic                               m_tlast
);
  import i2r_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  logic [SYM_W-1:0]  symbol;

  i2r_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  i2r_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .value    (s_tdata[VALUE_W-1:0]),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .symbol   (symbol),
    .last     (m_tlast)
  );

  assign m_tdata = {{(OUT_TDATA_W-SYM_W){1'b0}}, symbol};

endmodule

FILE: rtl/i2r_ctrl.sv
// Sequencer for the Roman numeral converter: accept, convert to BCD, emit symbols.
`timescale 1ns / 1ps

module i2r_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  i2r_pkg::stat_t stat,
  output i2r_pkg::cmd_t  cmd
);
  import i2r_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (stat.conv_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // advance only when the output register has room
        if (stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.run_done) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  conv_to_emit_a: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV && stat.conv_done) |=> (state == ST_EMIT))
    else $error("conversion end did not start emission");

  emit_to_idle_a: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && stat.out_free && stat.run_done) |=> (state == ST_IDLE))
    else $error("finished run did not return to idle");

  no_cmd_overlap_a: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.shift, cmd.step}))
    else $error("more than one datapath command at once");

endmodule

FILE: rtl/i2r_dpath.sv
// Datapath: double-dabble BCD conversion, digit/step counters and output register.
`timescale 1ns / 1ps

module i2r_dpath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [i2r_pkg::VALUE_W-1:0]           value,
  input  i2r_pkg::cmd_t                         cmd,
  output i2r_pkg::stat_t                        stat,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [i2r_pkg::SYM_W-1:0]             symbol,
  output logic                                  last
);
  import i2r_pkg::*;

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;
  logic [CNT_W-1:0]   cnt;
  logic [POS_W-1:0]   pos;
  logic [STEP_W-1:0]  step;

  logic [3:0]         cur_digit;
  logic [STEP_W-1:0]  cur_count;
  logic [SYM_W-1:0]   cur_sym;
  logic               lower_zero;
  logic               has_sym;
  logic               cur_last;

  // add 3 to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_comb begin
    cur_digit = bcd[{pos, 2'b00} +: 4];
    cur_count = digit_count(cur_digit, pos);
    cur_sym   = digit_symbol(cur_digit, pos, step);
    unique case (pos)
      2'd3:    lower_zero = (bcd[11:0] == '0);
      2'd2:    lower_zero = (bcd[7:0] == '0);
      2'd1:    lower_zero = (bcd[3:0] == '0);
      default: lower_zero = 1'b1;
    endcase
    has_sym  = (step < cur_count);
    cur_last = has_sym && (step == cur_count - 3'd1) && lower_zero;
  end

  always_comb begin
    stat.conv_done = (cnt == '0);
    stat.run_done  = has_sym ? cur_last : (pos == '0);
    stat.out_free  = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin  <= value;
      bcd  <= '0;
      cnt  <= LAST_SHIFT;
      pos  <= POS_THOU;
      step <= '0;
    end else if (cmd.shift) begin
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
      bin <= {bin[VALUE_W-2:0], 1'b0};
      cnt <= cnt - 4'd1;
    end else if (cmd.step) begin
      if (has_sym) begin
        step <= step + 3'd1;
      end else begin
        // digit exhausted: drop to the next lower position
        pos  <= pos - 2'd1;
        step <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && has_sym) begin
      symbol <= cur_sym;
      last   <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.step && has_sym) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  sym_range_a: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (symbol <= SYM_M))
    else $error("symbol code out of range");

  thou_is_m_a: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && has_sym && pos == POS_THOU) |=> (symbol == SYM_M))
    else $error("thousands position emitted a letter other than M");

  load_count_a: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (cnt == LAST_SHIFT && bcd == '0))
    else $error("conversion not initialized on load");

  no_overwrite_a: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(cmd.step && has_sym))
    else $error("pending output beat overwritten");

endmodule
